// File: rtl/core/ptc_pkg.sv
// Package with widths, register indexes and shared types for the pressure compensation block.
package ptc_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned QuotW = 32;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } reg_idx_t;

    localparam logic [31:0] B5Offset   = 32'd4000;
    localparam logic [31:0] B4Offset   = 32'd32768;
    localparam logic [31:0] B7Scale    = 32'd50000;
    localparam logic [31:0] SignBit    = 32'h8000_0000;
    localparam logic [31:0] PCoefSq    = 32'd3038;
    localparam logic [31:0] PCoefLin   = 32'hFFFF_E343; // -7357
    localparam logic [31:0] PCoefConst = 32'd3791;

    // Request for the shared-style pipelined divider.
    typedef struct packed {
        logic        vld;
        logic        neg;   // negate quotient (signed divide)
        logic [31:0] num;   // magnitude
        logic [31:0] den;   // magnitude
    } div_req_t;

endpackage

// File: rtl/core/ptc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with stall.
module ptc_div
    import ptc_pkg::*;
#(
    parameter int unsigned PAYW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  div_req_t            req,
    input  logic [PAYW-1:0]     pay_in,
    output logic                out_vld,
    output logic [31:0]         quo,
    output logic [PAYW-1:0]     pay_out
);

    localparam int unsigned N = QuotW;

    // Each stage owns its registers and reads the previous stage's ones.
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic              vld_in;
        logic              neg_in;
        logic [31:0]       rem_in;
        logic [31:0]       num_in;
        logic [31:0]       den_in;
        logic [PAYW-1:0]   pay_src;
        logic [32:0]       trial;
        logic [32:0]       shifted;
        logic              vld_reg;
        logic              neg_reg;
        logic [31:0]       num_reg;
        logic [PAYW-1:0]   pay_reg;

        if (s == 0)
        begin : g_src
            assign vld_in  = req.vld;
            assign neg_in  = req.neg;
            assign rem_in  = '0;
            assign num_in  = req.num;
            assign den_in  = req.den;
            assign pay_src = pay_in;
        end
        else
        begin : g_src
            assign vld_in  = g_stage[s-1].vld_reg;
            assign neg_in  = g_stage[s-1].neg_reg;
            assign rem_in  = g_stage[s-1].g_keep.rem_reg;
            assign num_in  = g_stage[s-1].num_reg;
            assign den_in  = g_stage[s-1].g_keep.den_reg;
            assign pay_src = g_stage[s-1].pay_reg;
        end

        always_comb
        begin
            shifted = {rem_in, num_in[31]};
            trial   = shifted - {1'b0, den_in};
        end

        // The last stage needs neither the partial remainder nor the divisor.
        if (s < N - 1)
        begin : g_keep
            logic [31:0] rem_reg;
            logic [31:0] den_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg <= den_in;
                    rem_reg <= trial[32] ? shifted[31:0] : trial[31:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_in;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg <= neg_in;
                pay_reg <= pay_src;
                num_reg <= {num_in[30:0], !trial[32]};
            end
        end
    end

    assign out_vld = g_stage[N-1].vld_reg;
    assign quo     = g_stage[N-1].neg_reg ? (32'd0 - g_stage[N-1].num_reg)
                                          : g_stage[N-1].num_reg;
    assign pay_out = g_stage[N-1].pay_reg;

endmodule

// File: rtl/core/pressure_temperature_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | raw_temperature[15:0], raw_pressure[18:0]
//  out     | out_valid/out_stall| temperature_tenths[15:0], pressure_pa[19:0], status
//  cfg     | cfg_valid/cfg_ready| cfg_index[2:0], cfg_data[31:0]
//
// One item enters per cycle when the output is not stalled. The pipeline is
// one input multiply stage, the two 32-stage dividers (temperature and
// pressure), four stages between them and three after the pressure divider,
// the last being the output register. The whole pipeline advances on one
// enable, so a stall holds every stage and nothing is lost or repeated. Reset
// clears valid bits and loads the default registers (all coefficients zero,
// oversampling three).
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        raw_temperature,
    input  logic [18:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature_tenths,
    output logic [19:0]        pressure_pa,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers.
    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg  <= '0;
            r1_reg  <= '0;
            r2_reg  <= '0;
            r3_reg  <= '0;
            r4_reg  <= '0;
            oss_reg <= 2'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AC1_AC2: r0_reg  <= cfg_data;
                REG_AC3_AC4: r1_reg  <= cfg_data;
                REG_AC5_AC6: r2_reg  <= cfg_data;
                REG_B1_B2:   r3_reg  <= cfg_data;
                REG_MC_MD:   r4_reg  <= cfg_data;
                REG_OSS:     oss_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Coefficients as 32-bit words: ac4, ac5 and ac6 zero-extended, the others sign-extended.
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    always_comb
    begin
        ac1 = {{16{r0_reg[31]}}, r0_reg[31:16]};
        ac2 = {{16{r0_reg[15]}}, r0_reg[15:0]};
        ac3 = {{16{r1_reg[31]}}, r1_reg[31:16]};
        ac4 = {16'd0, r1_reg[15:0]};
        ac5 = {16'd0, r2_reg[31:16]};
        ac6 = {16'd0, r2_reg[15:0]};
        b1  = {{16{r3_reg[31]}}, r3_reg[31:16]};
        b2  = {{16{r3_reg[15]}}, r3_reg[15:0]};
        mc  = {{16{r4_reg[31]}}, r4_reg[31:16]};
        md  = {{16{r4_reg[15]}}, r4_reg[15:0]};
    end

    // The whole pipeline moves together; the last stage is the output register.
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        begin
            s = $signed(v);
            asr = 32'(s >>> n);
        end
    endfunction

    // ---- stage A: ut - ac6, product with ac5 ----
    logic        a_vld_reg;
    logic [31:0] a_prod_reg;
    logic [18:0] a_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_vld_reg <= 1'b0;
        else if (en) a_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= 32'(({16'd0, raw_temperature} - ac6) * ac5);
            a_up_reg   <= raw_pressure;
        end
    end

    // ---- stage B: x1, den, divider request ----
    logic [31:0] b_x1;
    logic [31:0] b_den;
    logic [31:0] b_num;
    div_req_t    t_req;
    always_comb
    begin
        b_x1       = asr(a_prod_reg, 15);
        b_den      = b_x1 + md;
        b_num      = mc << 11;
        t_req.vld  = a_vld_reg;
        t_req.neg  = b_num[31] ^ b_den[31];
        t_req.num  = b_num[31] ? (32'd0 - b_num) : b_num;
        t_req.den  = b_den[31] ? (32'd0 - b_den) : b_den;
    end

    localparam int unsigned TPAYW = 32 + 19 + 1;
    logic              td_vld;
    logic [31:0]       td_quo;
    logic [TPAYW-1:0]  td_pay;

    ptc_div #(.PAYW(TPAYW)) u_tdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .req    (t_req),
        .pay_in ({b_x1, a_up_reg, (b_den == 32'd0)}),
        .out_vld(td_vld),
        .quo    (td_quo),
        .pay_out(td_pay)
    );

    // ---- stage C: b5, b6, b6*b6 and ac2*b6, ac3*b6 ----
    logic        c_vld_reg, c_err_reg;
    logic [31:0] c_b5_reg, c_sqp_reg, c_ac2p_reg, c_ac3p_reg;
    logic [18:0] c_up_reg;
    logic [31:0] c_b5, c_b6;
    always_comb
    begin
        c_b5 = td_pay[TPAYW-1 -: 32] + td_quo;
        c_b6 = c_b5 - B5Offset;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c_vld_reg <= 1'b0;
        else if (en) c_vld_reg <= td_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_err_reg  <= td_pay[0];
            c_up_reg   <= td_pay[19:1];
            c_b5_reg   <= c_b5;
            c_sqp_reg  <= 32'(c_b6 * c_b6);
            c_ac2p_reg <= 32'(ac2 * c_b6);
            c_ac3p_reg <= 32'(ac3 * c_b6);
        end
    end

    // ---- stage D: b2*sq, b1*sq ----
    logic        d_vld_reg, d_err_reg;
    logic [31:0] d_b5_reg, d_b2p_reg, d_b1p_reg, d_x2a_reg, d_x1c_reg;
    logic [18:0] d_up_reg;
    logic [31:0] d_sq;
    assign d_sq = asr(c_sqp_reg, 12);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) d_vld_reg <= 1'b0;
        else if (en) d_vld_reg <= c_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_err_reg <= c_err_reg;
            d_up_reg  <= c_up_reg;
            d_b5_reg  <= c_b5_reg;
            d_b2p_reg <= 32'(b2 * d_sq);
            d_b1p_reg <= 32'(b1 * d_sq);
            d_x2a_reg <= asr(c_ac2p_reg, 11);
            d_x1c_reg <= asr(c_ac3p_reg, 13);
        end
    end

    // ---- stage E: b3 and x3, then ac4*(x3+32768) ----
    logic        e_vld_reg, e_err_reg;
    logic [31:0] e_b5_reg, e_b3_reg, e_b4p_reg;
    logic [18:0] e_up_reg;
    logic [31:0] e_x3a, e_b3, e_x3b;
    always_comb
    begin
        e_x3a = asr(d_b2p_reg, 11) + d_x2a_reg;
        e_b3  = asr(((ac1 << 2) + e_x3a) << oss_reg, 0);
        e_b3  = asr(e_b3 + 32'd2, 2);
        e_x3b = asr(d_x1c_reg + asr(d_b1p_reg, 16) + 32'd2, 2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) e_vld_reg <= 1'b0;
        else if (en) e_vld_reg <= d_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_err_reg <= d_err_reg;
            e_up_reg  <= d_up_reg;
            e_b5_reg  <= d_b5_reg;
            e_b3_reg  <= e_b3;
            e_b4p_reg <= 32'(ac4 * (e_x3b + B4Offset));
        end
    end

    // ---- stage F: b4, b7 product ----
    logic        f_vld_reg, f_err_reg;
    logic [31:0] f_b5_reg, f_b4_reg, f_b7_reg;
    logic [31:0] f_b4;
    assign f_b4 = e_b4p_reg >> 15;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f_vld_reg <= 1'b0;
        else if (en) f_vld_reg <= e_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_err_reg <= e_err_reg || (f_b4 == 32'd0);
            f_b5_reg  <= e_b5_reg;
            f_b4_reg  <= f_b4;
            f_b7_reg  <= 32'(({13'd0, e_up_reg} - e_b3_reg) * (B7Scale >> oss_reg));
        end
    end

    // ---- pressure divider: (b7*2)/b4 or b7/b4 then doubled ----
    div_req_t p_req;
    logic     f_big;
    always_comb
    begin
        f_big     = f_b7_reg >= SignBit;
        p_req.vld = f_vld_reg;
        p_req.neg = 1'b0;
        p_req.num = f_big ? f_b7_reg : (f_b7_reg << 1);
        p_req.den = f_b4_reg;
    end

    localparam int unsigned PPAYW = 32 + 2;
    logic              pd_vld;
    logic [31:0]       pd_quo;
    logic [PPAYW-1:0]  pd_pay;

    ptc_div #(.PAYW(PPAYW)) u_pdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .req    (p_req),
        .pay_in ({f_b5_reg, f_big, f_err_reg}),
        .out_vld(pd_vld),
        .quo    (pd_quo),
        .pay_out(pd_pay)
    );

    // ---- stage G: p, (p>>8)^2, -7357*p ----
    logic        g_vld_reg, g_err_reg;
    logic [31:0] g_b5_reg, g_p_reg, g_sq_reg, g_lin_reg;
    logic [31:0] g_p, g_ps;
    always_comb
    begin
        g_p  = pd_pay[1] ? (pd_quo << 1) : pd_quo;
        g_ps = asr(g_p, 8);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) g_vld_reg <= 1'b0;
        else if (en) g_vld_reg <= pd_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_err_reg <= pd_pay[0];
            g_b5_reg  <= pd_pay[PPAYW-1 -: 32];
            g_p_reg   <= g_p;
            g_sq_reg  <= 32'(g_ps * g_ps);
            g_lin_reg <= 32'(PCoefLin * g_p);
        end
    end

    // ---- stage H: x1*3038 ----
    logic        h_vld_reg, h_err_reg;
    logic [31:0] h_b5_reg, h_p_reg, h_x1p_reg, h_x2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) h_vld_reg <= 1'b0;
        else if (en) h_vld_reg <= g_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_err_reg <= g_err_reg;
            h_b5_reg  <= g_b5_reg;
            h_p_reg   <= g_p_reg;
            h_x1p_reg <= 32'(g_sq_reg * PCoefSq);
            h_x2_reg  <= asr(g_lin_reg, 16);
        end
    end

    // ---- output stage: final pressure and saturation ----
    logic [31:0] o_pr, o_t;
    logic [15:0] o_temp;
    logic [19:0] o_pres;
    always_comb
    begin
        o_pr = h_p_reg + asr(asr(h_x1p_reg, 16) + h_x2_reg + PCoefConst, 4);
        o_t  = asr(h_b5_reg + 32'd8, 4);
        if ($signed(o_t) > 32'sd32767)
            o_temp = 16'h7FFF;
        else if ($signed(o_t) < -32'sd32768)
            o_temp = 16'h8000;
        else
            o_temp = o_t[15:0];
        if (o_pr[31])
            o_pres = '0;
        else if (o_pr > 32'd1048575)
            o_pres = 20'hFFFFF;
        else
            o_pres = o_pr[19:0];
    end

    logic        o_vld_reg;
    logic [15:0] o_temp_reg;
    logic [19:0] o_pres_reg;
    logic        o_err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) o_vld_reg <= 1'b0;
        else if (en) o_vld_reg <= h_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_err_reg  <= h_err_reg;
            o_temp_reg <= h_err_reg ? 16'd0 : o_temp;
            o_pres_reg <= h_err_reg ? 20'd0 : o_pres;
        end
    end

    assign out_valid          = o_vld_reg;
    assign temperature_tenths = $signed(o_temp_reg);
    assign pressure_pa        = o_pres_reg;
    assign status             = o_err_reg;

endmodule
